/* src/i2cms_pkg.sv */
`timescale 1ns / 1ps

package i2cms_pkg;

   // Request codes on req_type.
   localparam logic [2:0] REQ_START     = 3'd0;
   localparam logic [2:0] REQ_STOP      = 3'd1;
   localparam logic [2:0] REQ_WRITE     = 3'd2;
   localparam logic [2:0] REQ_READ_ACK  = 3'd3;
   localparam logic [2:0] REQ_READ_NACK = 3'd4;

   // Timing and acknowledge polling.
   localparam int HALF_BIT_US     = 4;
   localparam int ACK_TRIES       = 3;
   localparam int CARRIED_SAMPLES = 3;
   localparam int TRIES_USED      = (ACK_TRIES > CARRIED_SAMPLES) ? CARRIED_SAMPLES :
                                    ((ACK_TRIES < 1) ? 1 : ACK_TRIES);

   localparam logic [2:0] HOLD_HALF   = (HALF_BIT_US > 7) ? 3'd7 : 3'(HALF_BIT_US);
   localparam logic [2:0] HOLD_REL    = 3'd2;
   localparam logic [2:0] HOLD_SAMPLE = 3'd1;
   localparam logic [2:0] HOLD_NONE   = 3'd0;

   // Eight data bits, two line phases each.
   localparam int BIT_PHASES = 16;
   localparam int CNT_W      = $clog2(BIT_PHASES);

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [7:0]   rbits;
      logic         nack;
      logic         acked;
      logic [1:0]   extras;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_STOP,
      ST_WFIRST,
      ST_WBIT,
      ST_WREL,
      ST_WCLK,
      ST_WTRY,
      ST_WEND,
      ST_RBIT,
      ST_RACK
   } seq_state_type;

   function automatic seq_state_type first_state(cmd_kind_type kind);
      seq_state_type st;
      unique case (kind)
         CMD_START: st = ST_START;
         CMD_STOP:  st = ST_STOP;
         CMD_WRITE: st = ST_WFIRST;
         CMD_READ:  st = ST_RBIT;
         default:   st = ST_IDLE;
      endcase
      return st;
   endfunction

endpackage

/* src/i2cms_front.sv */
`timescale 1ns / 1ps

module i2cms_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_type,
   input  logic [7:0]             req_data_byte,
   input  logic [7:0]             req_read_bits,
   input  logic [2:0]             req_ack_samples,
   input  logic                   head_pop,
   output i2cms_pkg::q_head_type  head
);
   import i2cms_pkg::*;

   cmd_type             new_cmd;
   logic                cmd_ok;
   logic                ack_found;
   logic [1:0]          high_tries;
   logic                push;
   logic                pop;
   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   // Resolve the acknowledge poll up front: the back only needs to know
   // how many high tries to replay and whether the slave answered.
   always_comb begin
      logic done;
      done       = 1'b0;
      ack_found  = 1'b0;
      high_tries = 2'd0;
      for (int i = 0; i < CARRIED_SAMPLES; i++) begin
         if (i < TRIES_USED && !done) begin
            if (!req_ack_samples[i]) begin
               ack_found = 1'b1;
               done      = 1'b1;
            end else begin
               high_tries = high_tries + 2'd1;
            end
         end
      end
   end

   always_comb begin
      new_cmd        = '0;
      new_cmd.data   = req_data_byte;
      new_cmd.rbits  = req_read_bits;
      new_cmd.acked  = ack_found;
      new_cmd.extras = high_tries;
      cmd_ok         = 1'b1;
      unique case (req_type)
         REQ_START:     new_cmd.kind = CMD_START;
         REQ_STOP:      new_cmd.kind = CMD_STOP;
         REQ_WRITE:     new_cmd.kind = CMD_WRITE;
         REQ_READ_ACK:  new_cmd.kind = CMD_READ;
         REQ_READ_NACK: begin
            new_cmd.kind = CMD_READ;
            new_cmd.nack = 1'b1;
         end
         default:       cmd_ok = 1'b0;
      endcase
   end

   // Unknown requests are taken and dropped; they produce no line phases.
   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready && cmd_ok;
   assign pop       = head_pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* src/i2cms_back.sv */
`timescale 1ns / 1ps

module i2cms_back (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cms_pkg::q_head_type  head,
   output logic                   head_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_scl_level,
   output logic                   rsp_sda_level,
   output logic [2:0]             rsp_hold_us,
   output logic                   rsp_samples_line,
   output logic [7:0]             rsp_read_byte,
   output logic                   rsp_acked,
   output logic                   rsp_last
);
   import i2cms_pkg::*;

   seq_state_type      state_ff, state_in, nxt_state;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, nxt_cnt;
   cmd_type            cmd_ff, cmd_in;

   logic               out_free;
   logic               emit;
   logic               scl, sda, smp, lst, ack;
   logic [2:0]         hold;
   logic [7:0]         rbyte;
   logic               bit_sel;
   logic               cnt_end;

   logic               rsp_valid_ff;
   logic               rsp_scl_ff, rsp_sda_ff, rsp_smp_ff, rsp_ack_ff, rsp_last_ff;
   logic [2:0]         rsp_hold_ff;
   logic [7:0]         rsp_rbyte_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign bit_sel  = cmd_ff.data[3'd7 - 3'(cnt_ff[CNT_W-1:1])];
   assign cnt_end  = (cnt_ff == CNT_W'(BIT_PHASES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      cmd_ff <= cmd_in;
   end

   always_comb begin
      emit      = 1'b0;
      scl       = 1'b0;
      sda       = 1'b0;
      hold      = HOLD_NONE;
      smp       = 1'b0;
      lst       = 1'b0;
      ack       = 1'b0;
      rbyte     = '0;
      nxt_state = state_ff;
      nxt_cnt   = cnt_ff + 1'b1;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      head_pop  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               cmd_in   = head.cmd;
               state_in = first_state(head.cmd.kind);
               cnt_in   = '0;
            end
         end
         ST_START: begin
            emit = 1'b1;
            scl  = (cnt_ff != CNT_W'(2));
            sda  = (cnt_ff == '0);
            hold = (cnt_ff == CNT_W'(2)) ? HOLD_NONE : HOLD_HALF;
            lst  = (cnt_ff == CNT_W'(2));
         end
         ST_STOP: begin
            // Shared by the stop request and by a write the slave refused.
            emit = 1'b1;
            scl  = (cnt_ff != '0);
            sda  = (cnt_ff == CNT_W'(2));
            hold = (cnt_ff == '0) ? HOLD_NONE : HOLD_HALF;
            if (cnt_ff == CNT_W'(2)) begin
               if (cmd_ff.kind == CMD_STOP) begin
                  lst = 1'b1;
               end else begin
                  nxt_state = ST_WEND;
                  nxt_cnt   = '0;
               end
            end
         end
         ST_WFIRST: begin
            emit      = 1'b1;
            sda       = cmd_ff.data[7];
            hold      = HOLD_HALF;
            nxt_state = ST_WBIT;
            nxt_cnt   = '0;
         end
         ST_WBIT: begin
            emit = 1'b1;
            scl  = cnt_ff[0];
            sda  = bit_sel;
            hold = HOLD_HALF;
            if (cnt_end) begin
               nxt_state = ST_WREL;
               nxt_cnt   = '0;
            end
         end
         ST_WREL: begin
            emit      = 1'b1;
            sda       = 1'b1;
            hold      = HOLD_REL;
            nxt_state = ST_WCLK;
         end
         ST_WCLK: begin
            emit    = 1'b1;
            scl     = 1'b1;
            sda     = 1'b1;
            hold    = HOLD_SAMPLE;
            smp     = 1'b1;
            nxt_cnt = '0;
            if (cmd_ff.extras != 2'd0) begin
               nxt_state = ST_WTRY;
            end else if (cmd_ff.acked) begin
               nxt_state = ST_WEND;
            end else begin
               nxt_state = ST_STOP;
            end
         end
         ST_WTRY: begin
            // One more clock-high phase per try that saw SDA high.
            emit = 1'b1;
            scl  = 1'b1;
            sda  = 1'b1;
            hold = HOLD_SAMPLE;
            smp  = (int'(cnt_ff) + 1 < TRIES_USED);
            if (cnt_ff[1:0] + 2'd1 == cmd_ff.extras) begin
               nxt_state = cmd_ff.acked ? ST_WEND : ST_STOP;
               nxt_cnt   = '0;
            end
         end
         ST_WEND: begin
            emit = 1'b1;
            sda  = 1'b1;
            lst  = 1'b1;
            ack  = cmd_ff.acked;
         end
         ST_RBIT: begin
            emit = 1'b1;
            scl  = cnt_ff[0];
            sda  = 1'b1;
            hold = cnt_ff[0] ? HOLD_SAMPLE : HOLD_HALF;
            smp  = cnt_ff[0];
            if (cnt_end) begin
               nxt_state = ST_RACK;
               nxt_cnt   = '0;
            end
         end
         ST_RACK: begin
            emit = 1'b1;
            scl  = (cnt_ff == CNT_W'(1));
            sda  = cmd_ff.nack;
            hold = (cnt_ff == CNT_W'(2)) ? HOLD_NONE : HOLD_HALF;
            if (cnt_ff == CNT_W'(2)) begin
               lst   = 1'b1;
               rbyte = cmd_ff.rbits;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Advance only when the phase lands in the output register. On the
      // last phase the next queued command is picked up without a gap.
      if (emit && out_free) begin
         state_in = nxt_state;
         cnt_in   = nxt_cnt;
         if (lst) begin
            if (head.valid) begin
               head_pop = 1'b1;
               cmd_in   = head.cmd;
               state_in = first_state(head.cmd.kind);
               cnt_in   = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_scl_ff   <= scl;
         rsp_sda_ff   <= sda;
         rsp_hold_ff  <= hold;
         rsp_smp_ff   <= smp;
         rsp_rbyte_ff <= rbyte;
         rsp_ack_ff   <= ack;
         rsp_last_ff  <= lst;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_level    = rsp_scl_ff;
   assign rsp_sda_level    = rsp_sda_ff;
   assign rsp_hold_us      = rsp_hold_ff;
   assign rsp_samples_line = rsp_smp_ff;
   assign rsp_read_byte    = rsp_rbyte_ff;
   assign rsp_acked        = rsp_ack_ff;
   assign rsp_last         = rsp_last_ff;

   a_result_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_rbyte_ff == 8'd0 && !rsp_ack_ff)
      else $error("read byte or ack flag set on a phase that is not last");

   a_acked_on_write_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ack_ff |-> rsp_last_ff && !rsp_scl_ff && rsp_sda_ff)
      else $error("ack flag outside the closing phase of a write");

   a_try_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WTRY |-> cnt_ff[1:0] < cmd_ff.extras)
      else $error("acknowledge retry count ran past the recorded tries");

   a_pop_at_boundary: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head.valid && (state_ff == ST_IDLE || (emit && lst && out_free)))
      else $error("command popped in the middle of another command");

endmodule

/* src/i2c_master_byte_sequencer.sv */
`timescale 1ns / 1ps
// The first line phase word of a command accepted while the sequencer is idle passes
// through the queue, the command load and then the output register. Throughput: one
// line phase word per cycle while the result side is ready; a command gives as many
// words as it has phases (3 for start or stop, 19 for a read, 20 to 26 for a write),
// plus a load step when the two-entry queue had run empty. Synchronous active-high reset
// empties the queue, returns the sequencer to idle and drops any pending result word.

module i2c_master_byte_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_type,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_read_bits,
   input  logic [2:0] req_ack_samples,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic [2:0] rsp_hold_us,
   output logic       rsp_samples_line,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_acked,
   output logic       rsp_last
);
   import i2cms_pkg::*;

   // The front decodes each command word, resolves the acknowledge poll and
   // queues it. Unknown command codes are accepted and produce nothing.
   q_head_type head;
   logic       head_pop;

   i2cms_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_data_byte   (req_data_byte),
      .req_read_bits   (req_read_bits),
      .req_ack_samples (req_ack_samples),
      .head_pop        (head_pop),
      .head            (head)
   );

   // The back walks the line phases of one command at a time into an
   // output register; a stalled result side holds it, and a full queue then blocks the front.
   i2cms_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_level    (rsp_sda_level),
      .rsp_hold_us      (rsp_hold_us),
      .rsp_samples_line (rsp_samples_line),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_acked        (rsp_acked),
      .rsp_last         (rsp_last)
   );

endmodule

/* verif/i2c_master_byte_sequencer_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the byte-level I2C line sequencer.
// Every command word that the block accepts is expanded here into the SCL/SDA line phase
// words it must produce. Each phase word that leaves the block is checked against the
// oldest phase still outstanding.
module i2c_master_byte_sequencer_tb;
   import i2cms_pkg::*;

   // Codes 5 to 7 on req_type are not commands, and the block must drop them silently.
   localparam logic [2:0] REQ_BAD_LO = 3'd5;
   localparam logic [2:0] REQ_BAD_HI = 3'd7;

   // A write with no acknowledge at all is the longest command at 26 phase words. The
   // receiver stalls and the sender pauses are both bounded by pick_gap. About 290 commands
   // therefore stay well under the watchdog limit, which allows several times their run.
   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   // These are the cycles to wait once nothing is outstanding, so that a stray word
   // caused by a dropped code still has time to show up.
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned RANDOM_ITEMS = 270;

   typedef struct packed {
      bit       scl;
      bit       sda;
      bit [2:0] hold;
      bit       smp;
      bit [7:0] rbyte;
      bit       acked;
      bit       last;
   } phase_word_type;

   // Expands command words into line phase words and keeps those still owed by the block.
   class phase_tracker;
      phase_word_type owed_q[$];
      int unsigned mismatches;
      int unsigned phases_checked;
      int unsigned acked_writes;
      int unsigned nacked_writes;
      int unsigned cmd_count[8];

      function void push_phase(bit scl, bit sda, bit [2:0] hold, bit smp);
         phase_word_type w;
         w = '{scl: scl, sda: sda, hold: hold, smp: smp, rbyte: 8'h00, acked: 1'b0,
               last: 1'b0};
         owed_q.push_back(w);
      endfunction

      function void push_stop(bit [2:0] h);
         push_phase(1'b0, 1'b0, 3'd0, 1'b0);
         push_phase(1'b1, 1'b0, h, 1'b0);
         push_phase(1'b1, 1'b1, h, 1'b0);
      endfunction

      function void note_command(logic [2:0] kind, logic [7:0] data, logic [7:0] rbits,
                                 logic [2:0] asmp);
         bit [2:0]       h;
         int unsigned    tries;
         int unsigned    first;
         bit             ack;
         bit             ack_bit;
         bit [7:0]       shifter;
         bit [7:0]       rbyte;
         phase_word_type tail;
         h       = (HALF_BIT_US > 7) ? 3'd7 : 3'(HALF_BIT_US);
         tries   = (ACK_TRIES > CARRIED_SAMPLES) ? CARRIED_SAMPLES : ACK_TRIES;
         tries   = (tries == 0) ? 1 : tries;
         first   = owed_q.size();
         ack     = 1'b0;
         rbyte   = 8'h00;
         shifter = data;
         cmd_count[kind]++;
         case (kind)
            REQ_START: begin
               push_phase(1'b1, 1'b1, h, 1'b0);
               push_phase(1'b1, 1'b0, h, 1'b0);
               push_phase(1'b0, 1'b0, 3'd0, 1'b0);
            end
            REQ_STOP: begin
               push_stop(h);
            end
            REQ_WRITE: begin
               push_phase(1'b0, shifter[7], h, 1'b0);
               for (int i = 0; i < 8; i++) begin
                  push_phase(1'b0, shifter[7], h, 1'b0);
                  push_phase(1'b1, shifter[7], h, 1'b0);
                  shifter = shifter << 1;
               end
               push_phase(1'b0, 1'b1, 3'd2, 1'b0);
               push_phase(1'b1, 1'b1, 3'd1, 1'b1);
               for (int i = 0; i < tries; i++) begin
                  if (!asmp[i]) begin
                     ack = 1'b1;
                     break;
                  end
                  push_phase(1'b1, 1'b1, 3'd1, (i + 1 < tries));
               end
               if (!ack) push_stop(h);
               push_phase(1'b0, 1'b1, 3'd0, 1'b0);
               if (ack) acked_writes++;
               else nacked_writes++;
            end
            REQ_READ_ACK, REQ_READ_NACK: begin
               for (int i = 0; i < 8; i++) begin
                  push_phase(1'b0, 1'b1, h, 1'b0);
                  push_phase(1'b1, 1'b1, 3'd1, 1'b1);
               end
               rbyte   = rbits;
               ack_bit = (kind == REQ_READ_NACK);
               push_phase(1'b0, ack_bit, h, 1'b0);
               push_phase(1'b1, ack_bit, h, 1'b0);
               push_phase(1'b0, ack_bit, 3'd0, 1'b0);
            end
            default: begin
            end
         endcase
         if (owed_q.size() > first) begin
            tail       = owed_q[$];
            tail.rbyte = rbyte;
            tail.acked = ack;
            tail.last  = 1'b1;
            owed_q[owed_q.size() - 1] = tail;
         end
      endfunction

      function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
         if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_phase(phase_word_type got);
         phase_word_type exp_w;
         if (owed_q.size() == 0) begin
            $error("phase word arrived with none outstanding");
            mismatches++;
            return;
         end
         exp_w = owed_q.pop_front();
         phases_checked++;
         compare_field("scl_level", exp_w.scl, got.scl);
         compare_field("sda_level", exp_w.sda, got.sda);
         compare_field("hold_us", exp_w.hold, got.hold);
         compare_field("samples_line", exp_w.smp, got.smp);
         compare_field("read_byte", exp_w.rbyte, got.rbyte);
         compare_field("acked", exp_w.acked, got.acked);
         compare_field("last", exp_w.last, got.last);
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_type;
   logic [7:0] req_data_byte;
   logic [7:0] req_read_bits;
   logic [2:0] req_ack_samples;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_scl_level;
   logic       rsp_sda_level;
   logic [2:0] rsp_hold_us;
   logic       rsp_samples_line;
   logic [7:0] rsp_read_byte;
   logic       rsp_acked;
   logic       rsp_last;

   phase_tracker tracker = new();

   // While calm is set, neither side idles, so the block runs at full rate.
   bit          calm;
   int unsigned stall_left;
   int unsigned cycles;

   i2c_master_byte_sequencer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_data_byte   (req_data_byte),
      .req_read_bits   (req_read_bits),
      .req_ack_samples (req_ack_samples),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_hold_us     (rsp_hold_us),
      .rsp_samples_line(rsp_samples_line),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_acked       (rsp_acked),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Most pauses are short or absent. A few are long enough to back the queue up
   // completely.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // The result side stalls at random. Stalls are drawn at the falling edge, so they
   // land on any phase word of any command.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Both handshakes are observed at the rising edge. The values read here are the ones
   // that the block itself sees at that edge.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d phase words outstanding", cycles,
                  tracker.pending());
         $display("FAILURE");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_command(req_type, req_data_byte, req_read_bits, req_ack_samples);
         if (rsp_valid && rsp_ready)
            tracker.check_phase('{scl: rsp_scl_level, sda: rsp_sda_level,
                                  hold: rsp_hold_us, smp: rsp_samples_line,
                                  rbyte: rsp_read_byte, acked: rsp_acked,
                                  last: rsp_last});
      end
   end

   // The task is entered at a falling edge. It raises valid with the command word and
   // holds it until the word is taken. It then leaves at a falling edge, either still
   // driving valid so that the next word follows back to back, or after a pause.
   task automatic send_command(input logic [2:0] kind, input logic [7:0] data,
                               input logic [7:0] rbits, input logic [2:0] asmp);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_data_byte   <= data;
      req_read_bits   <= rbits;
      req_ack_samples <= asmp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // A random command word. Fields that the command does not use are still random, so
   // that the block is seen to ignore them.
   task automatic send_random();
      int unsigned r;
      logic [2:0]  kind;
      r = $urandom_range(0, 99);
      if (r < 15)      kind = REQ_START;
      else if (r < 30) kind = REQ_STOP;
      else if (r < 62) kind = REQ_WRITE;
      else if (r < 78) kind = REQ_READ_ACK;
      else if (r < 94) kind = REQ_READ_NACK;
      else             kind = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      send_command(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = REQ_START;
      req_data_byte   = 8'h00;
      req_read_bits   = 8'h00;
      req_ack_samples = 3'd0;
      rsp_ready       = 1'b0;
      calm            = 1'b0;
      stall_left      = 0;
      cycles          = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed commands. A framed transfer comes first, with writes that are
      // acknowledged on the first, second and third sample and one that gets no
      // acknowledge at all. The byte extremes are sent both ways, then reads with
      // acknowledge and without, every code that is not a command, and a last start and stop.
      send_command(REQ_START, 8'h00, 8'h00, 3'd0);
      send_command(REQ_WRITE, 8'h00, 8'hFF, 3'b000);
      send_command(REQ_WRITE, 8'hFF, 8'h00, 3'b111);
      send_command(REQ_WRITE, 8'h5A, 8'hA5, 3'b001);
      send_command(REQ_WRITE, 8'hA5, 8'h5A, 3'b011);
      send_command(REQ_WRITE, 8'h80, 8'h01, 3'b110);
      send_command(REQ_WRITE, 8'h01, 8'h80, 3'b101);
      send_command(REQ_READ_ACK, 8'hFF, 8'hFF, 3'b111);
      send_command(REQ_READ_ACK, 8'h00, 8'h81, 3'b000);
      send_command(REQ_READ_NACK, 8'hFF, 8'h00, 3'b111);
      send_command(REQ_READ_NACK, 8'h00, 8'h7E, 3'b010);
      send_command(REQ_STOP, 8'hFF, 8'hFF, 3'b111);
      send_command(REQ_BAD_LO, 8'hFF, 8'hFF, 3'b111);
      send_command(3'd6, 8'h00, 8'h00, 3'b000);
      send_command(REQ_BAD_HI, 8'h3C, 8'hC3, 3'b100);
      send_command(REQ_START, 8'h00, 8'h00, 3'd0);
      send_command(REQ_STOP, 8'h00, 8'h00, 3'd0);

      // Random commands. One stretch in the middle runs with no idling on either side.
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 100 && i < 140);
         send_random();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d start, %0d stop, %0d write, %0d read-ack, %0d read-nack commands",
               tracker.cmd_count[REQ_START], tracker.cmd_count[REQ_STOP],
               tracker.cmd_count[REQ_WRITE], tracker.cmd_count[REQ_READ_ACK],
               tracker.cmd_count[REQ_READ_NACK]);
      $display("writes acked %0d / not acked %0d, %0d phase words checked, %0d mismatches",
               tracker.acked_writes, tracker.nacked_writes, tracker.phases_checked,
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
